/* hdl/wbcd_pkg.sv */
// ----------------------------------------------------------------------------
// wbcd_pkg
// Shared widths, register indexes and the divider request type for the
// wrench bias calibration and contact detection block.
// ----------------------------------------------------------------------------
`default_nettype none

package wbcd_pkg;

  localparam int NUM_CH     = 6;
  localparam int SAMPLE_W   = 24;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int SUM_W      = 36;
  localparam int CNT_W      = 13;
  localparam int THR_W      = 23;
  localparam int BITCNT_W   = 6;
  localparam int CH_W       = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int DATA_W     = NUM_CH * SAMPLE_W;
  localparam int USER_W     = 2;

  localparam logic [CNT_W-1:0] MAX_BIAS_SAMPLES   = CNT_W'(4096);
  localparam logic [CNT_W-1:0] BIAS_SAMPLES_RESET = CNT_W'(100);
  localparam logic [THR_W-1:0] THRESHOLD_RESET    = THR_W'(307);

  localparam logic [CFG_IDX_W-1:0] REG_BIAS_SAMPLES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CONTACT_THR  = CFG_IDX_W'(1);

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

endpackage

`default_nettype wire

/* hdl/wbcd_div.sv */
// ----------------------------------------------------------------------------
// wbcd_div
// Restoring divider, one quotient bit per cycle: signed channel sum over
// unsigned sample count, quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wbcd_div import wbcd_pkg::*; (
  input  wire                        clk,
  input  wire                        rst,
  input  div_req_t                   req,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] quot
);

  logic                busy;
  logic [BITCNT_W-1:0] step;
  logic [SUM_W-1:0]    qsh;
  logic [CNT_W-1:0]    rem;
  logic [CNT_W-1:0]    dvs;
  logic                neg;
  logic [SUM_W-1:0]    mag;
  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      trial_sub;
  logic                ge;
  logic [SAMPLE_W-1:0] qmag;

  assign mag       = req.dividend[SUM_W-1] ? (~req.dividend + SUM_W'(1)) : req.dividend;
  assign trial     = {rem, qsh[SUM_W-1]};
  assign trial_sub = trial - {1'b0, dvs};
  assign ge        = trial >= {1'b0, dvs};
  assign qmag      = qsh[SAMPLE_W-1:0];
  assign quot      = neg ? (~qmag + SAMPLE_W'(1)) : qmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        qsh  <= mag;
        rem  <= '0;
        dvs  <= req.divisor;
        neg  <= req.dividend[SUM_W-1];
      end else if (busy) begin
        qsh  <= {qsh[SUM_W-2:0], ge};
        rem  <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
        step <= step + BITCNT_W'(1);
        if (step == BITCNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/wrench_bias_calibrate_contact_detect.sv */
// ----------------------------------------------------------------------------
// wrench_bias_calibrate_contact_detect
// Six-axis force/torque zero-offset calibration with Z contact detection.
//
// Input items arrive on the s_ stream, one six-channel sample per item, and
// each produces exactly one result item on the m_ stream. Registers are set
// through the cfg_ write channel, which is always ready.
// After reset the block collects bias_samples samples (zero taken as one,
// capped at 4096) into 36-bit sums, then divides each sum by the count in
// a shared one-bit-per-cycle divider. Later samples get the bias subtracted
// and saturated to 24 bits; in_contact is set when |corrected Z| exceeds
// contact_threshold. Datapaths are bit serial, all six channels side by side:
//   calibrating item: serial accumulation into the sums,
//   final calibrating item: then the six divisions, one per channel,
//   corrected item: serial subtraction of the bias.
// One item is in work at a time; s_tready is high only when idle.
// Results sit in an output register, so a new item is taken while a result
// waits. If the receiver stalls, the next result holds until m_tready.
// Reset clears sums, biases, count and flags, and restarts calibration.
// ----------------------------------------------------------------------------
`default_nettype none

module wrench_bias_calibrate_contact_detect import wbcd_pkg::*; (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_tvalid,
  output logic                  s_tready,
  // force_x, force_y, force_z, torque_x, torque_y, torque_z
  input  wire  [DATA_W-1:0]     s_tdata,
  output logic                  m_tvalid,
  input  wire                   m_tready,
  // corr_force_x, corr_force_y, corr_force_z, corr_torque_x, corr_torque_y,
  // corr_torque_z
  output logic [DATA_W-1:0]     m_tdata,
  // calibrating, in_contact
  output logic [USER_W-1:0]     m_tuser,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CAL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_COR  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]          state;
  logic [BITCNT_W-1:0] bitcnt;
  logic [CH_W-1:0]     ch;
  logic                collecting;
  logic [CNT_W-1:0]    sample_count;
  logic                cal_last;
  logic                contact_flag;
  logic [CNT_W-1:0]    bias_samples;
  logic [THR_W-1:0]    contact_threshold;
  logic                res_cal;
  logic                div_go;

  logic [SUM_W-1:0]    work  [NUM_CH];
  logic [SUM_W-1:0]    sums  [NUM_CH];
  logic [SAMPLE_W-1:0] bias  [NUM_CH];
  logic [DIFF_W-1:0]   bwork [NUM_CH];
  logic [DIFF_W-1:0]   diff  [NUM_CH];
  logic [NUM_CH-1:0]   carry;

  logic [NUM_CH-1:0]   add_bit, add_cy, sub_bit, sub_cy;
  logic [SAMPLE_W-1:0] corr  [NUM_CH];
  logic [CNT_W-1:0]    target;
  logic [CNT_W-1:0]    cnt_inc;
  logic [SAMPLE_W-1:0] abs_z;
  logic                new_contact;
  logic                out_free;

  div_req_t                   div_req;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] div_quot;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  assign target = (bias_samples == '0) ? CNT_W'(1) :
                  (bias_samples > MAX_BIAS_SAMPLES) ? MAX_BIAS_SAMPLES : bias_samples;
  assign cnt_inc = sample_count + CNT_W'(1);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      add_bit[c] = work[c][0] ^ sums[c][0] ^ carry[c];
      add_cy[c]  = (work[c][0] & sums[c][0]) | (carry[c] & (work[c][0] ^ sums[c][0]));
      sub_bit[c] = work[c][0] ^ ~bwork[c][0] ^ carry[c];
      sub_cy[c]  = (work[c][0] & ~bwork[c][0]) | (carry[c] & (work[c][0] ^ ~bwork[c][0]));
      if (diff[c][DIFF_W-1] != diff[c][DIFF_W-2]) begin
        corr[c] = diff[c][DIFF_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                    : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
        corr[c] = diff[c][SAMPLE_W-1:0];
      end
    end
  end

  assign abs_z       = corr[2][SAMPLE_W-1] ? (~corr[2] + SAMPLE_W'(1)) : corr[2];
  assign new_contact = {1'b0, abs_z} > {2'b00, contact_threshold};

  assign div_req.start    = div_go;
  assign div_req.dividend = sums[ch];
  assign div_req.divisor  = sample_count;

  wbcd_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      bitcnt            <= '0;
      ch                <= '0;
      collecting        <= 1'b1;
      sample_count      <= '0;
      cal_last          <= 1'b0;
      contact_flag      <= 1'b0;
      bias_samples      <= BIAS_SAMPLES_RESET;
      contact_threshold <= THRESHOLD_RESET;
      res_cal           <= 1'b0;
      div_go            <= 1'b0;
      m_tvalid          <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        sums[c] <= '0;
        bias[c] <= '0;
      end
    end else begin
      if (m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        if (cfg_index == REG_BIAS_SAMPLES) begin
          bias_samples <= cfg_data[CNT_W-1:0];
        end else if (cfg_index == REG_CONTACT_THR) begin
          contact_threshold <= cfg_data[THR_W-1:0];
        end
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            for (int c = 0; c < NUM_CH; c++) begin
              work[c]  <= {{(SUM_W-SAMPLE_W){s_tdata[c*SAMPLE_W+SAMPLE_W-1]}},
                           s_tdata[c*SAMPLE_W +: SAMPLE_W]};
              bwork[c] <= {bias[c][SAMPLE_W-1], bias[c]};
            end
            carry  <= collecting ? '0 : '1;
            bitcnt <= '0;
            if (collecting) begin
              sample_count <= cnt_inc;
              cal_last     <= (cnt_inc >= target);
              state        <= ST_CAL;
            end else begin
              state <= ST_COR;
            end
          end
        end
        ST_CAL: begin
          for (int c = 0; c < NUM_CH; c++) begin
            sums[c] <= {add_bit[c], sums[c][SUM_W-1:1]};
            work[c] <= {1'b0, work[c][SUM_W-1:1]};
          end
          carry  <= add_cy;
          bitcnt <= bitcnt + BITCNT_W'(1);
          if (bitcnt == BITCNT_W'(SUM_W - 1)) begin
            if (cal_last) begin
              collecting <= 1'b0;
              ch         <= '0;
              div_go     <= 1'b1;
              state      <= ST_DIV;
            end else begin
              res_cal <= 1'b1;
              state   <= ST_DONE;
            end
          end
        end
        ST_DIV: begin
          div_go <= div_done && (ch != CH_W'(NUM_CH - 1));
          if (div_done) begin
            bias[ch] <= div_quot;
            if (ch == CH_W'(NUM_CH - 1)) begin
              res_cal <= 1'b1;
              state   <= ST_DONE;
            end else begin
              ch <= ch + CH_W'(1);
            end
          end
        end
        ST_COR: begin
          for (int c = 0; c < NUM_CH; c++) begin
            diff[c]  <= {sub_bit[c], diff[c][DIFF_W-1:1]};
            work[c]  <= {1'b0, work[c][SUM_W-1:1]};
            bwork[c] <= {1'b0, bwork[c][DIFF_W-1:1]};
          end
          carry  <= sub_cy;
          bitcnt <= bitcnt + BITCNT_W'(1);
          if (bitcnt == BITCNT_W'(DIFF_W - 1)) begin
            res_cal <= 1'b0;
            state   <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (res_cal) begin
              m_tdata <= '0;
              m_tuser <= {contact_flag, 1'b1};
            end else begin
              for (int c = 0; c < NUM_CH; c++) begin
                m_tdata[c*SAMPLE_W +: SAMPLE_W] <= corr[c];
              end
              m_tuser      <= {new_contact, 1'b0};
              contact_flag <= new_contact;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/wbcd_chk.sv */
// ----------------------------------------------------------------------------
// wbcd_chk
// Port-level checks for the wrench bias calibration block, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wbcd_chk import wbcd_pkg::*; (
  input wire                  clk,
  input wire                  rst,
  input wire                  m_tvalid,
  input wire                  m_tready,
  input wire [DATA_W-1:0]     m_tdata,
  input wire [USER_W-1:0]     m_tuser
);

  logic seen_corrected;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_corrected <= 1'b0;
    end else if (m_tvalid && m_tready && !m_tuser[0]) begin
      seen_corrected <= 1'b1;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_cal_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
    else $error("calibrating result carries data or contact");

  a_cal_once: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && seen_corrected |-> !m_tuser[0])
    else $error("calibrating result after a corrected one");

endmodule

bind wrench_bias_calibrate_contact_detect wbcd_chk u_wbcd_chk (.*);

`default_nettype wire

/* bench/wrench_result_checker.sv */
// ----------------------------------------------------------------------------
// wrench_result_checker
// Watches the sample, result and register channels of the wrench bias
// calibration block. It keeps its own copy of the calibration sums, the
// biases, the contact flag and both registers, predicts one result per
// accepted sample and compares every accepted result with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module wrench_result_checker import wbcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [DATA_W-1:0]     s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [DATA_W-1:0]     m_tdata,
  input  logic [USER_W-1:0]     m_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);

  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] wrench_vec_t;

  typedef struct packed {
    logic        calibrating;
    wrench_vec_t corr;
    logic        in_contact;
  } wrench_result_t;

  localparam longint SAT_HI = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAT_LO = -(64'sd1 <<< (SAMPLE_W - 1));

  logic signed [SUM_W-1:0]    cal_sums [NUM_CH];
  logic signed [SAMPLE_W-1:0] ch_bias  [NUM_CH];
  logic [CNT_W-1:0]           cal_count;
  logic                       collecting;
  logic                       contact;
  logic [CNT_W-1:0]           bias_target;
  logic [THR_W-1:0]           contact_thr;

  wrench_result_t expected_wrench [$];
  wrench_result_t want;
  wrench_result_t got;
  int             fail_cnt = 0;

  task automatic predict_wrench(input wrench_vec_t raw);
    wrench_result_t res;
    longint         diff;
    longint         mag;
    int             target;
    res = '0;
    if (collecting) begin
      target = int'(bias_target);
      if (target < 1) target = 1;
      if (target > int'(MAX_BIAS_SAMPLES)) target = int'(MAX_BIAS_SAMPLES);
      for (int i = 0; i < NUM_CH; i++) begin
        cal_sums[i] = cal_sums[i] + $signed(raw[i]);
      end
      cal_count = cal_count + 1'b1;
      if (int'(cal_count) >= target) begin
        for (int i = 0; i < NUM_CH; i++) begin
          diff       = longint'(cal_sums[i]) / longint'(cal_count);
          ch_bias[i] = diff[SAMPLE_W-1:0];
        end
        collecting = 1'b0;
      end
      res.calibrating = 1'b1;
      res.in_contact  = contact;
    end else begin
      for (int i = 0; i < NUM_CH; i++) begin
        diff = longint'($signed(raw[i])) - longint'(ch_bias[i]);
        if (diff > SAT_HI) diff = SAT_HI;
        if (diff < SAT_LO) diff = SAT_LO;
        res.corr[i] = diff[SAMPLE_W-1:0];
        if (i == 2) mag = (diff < 0) ? -diff : diff;
      end
      contact        = mag > longint'(contact_thr);
      res.in_contact = contact;
    end
    expected_wrench.insert(expected_wrench.size(), res);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        cal_sums[i] = '0;
        ch_bias[i]  = '0;
      end
      cal_count   = '0;
      collecting  = 1'b1;
      contact     = 1'b0;
      bias_target = BIAS_SAMPLES_RESET;
      contact_thr = THRESHOLD_RESET;
      expected_wrench.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.calibrating = m_tuser[0];
        got.in_contact  = m_tuser[1];
        got.corr        = m_tdata;
        if (expected_wrench.size() == 0) begin
          $display("%0t: result item with none expected, tdata %h tuser %b",
                   $time, m_tdata, m_tuser);
          fail_cnt++;
        end else begin
          want = expected_wrench.pop_front();
          if (got.calibrating !== want.calibrating) begin
            $display("%0t: calibrating expected %b actual %b",
                     $time, want.calibrating, got.calibrating);
            fail_cnt++;
          end
          for (int i = 0; i < NUM_CH; i++) begin
            if (got.corr[i] !== want.corr[i]) begin
              $display("%0t: channel %0d expected %h actual %h",
                       $time, i, want.corr[i], got.corr[i]);
              fail_cnt++;
            end
          end
          if (got.in_contact !== want.in_contact) begin
            $display("%0t: in_contact expected %b actual %b",
                     $time, want.in_contact, got.in_contact);
            fail_cnt++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BIAS_SAMPLES) bias_target = cfg_data[CNT_W-1:0];
        else if (cfg_index == REG_CONTACT_THR) contact_thr = cfg_data[THR_W-1:0];
      end
      if (s_tvalid && s_tready) predict_wrench(s_tdata);
    end
    mismatches <= fail_cnt;
    pending    <= expected_wrench.size();
  end

endmodule

/* bench/wrench_bias_calibrate_contact_detect_tb.sv */
// ----------------------------------------------------------------------------
// wrench_bias_calibrate_contact_detect_tb
// Drives the calibration block through one calibration after reset, with the
// sample target raised past its cap and then dropped below the count, and
// then through corrected samples under several contact thresholds. Samples
// during calibration keep Z at a fixed value so the Z bias is exact and the
// contact edge can be aimed at. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module wrench_bias_calibrate_contact_detect_tb;
  import wbcd_pkg::*;

  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] wrench_vec_t;

  typedef enum logic [1:0] {RDY_OPEN, RDY_MOSTLY, RDY_SPARSE, RDY_PULSE} ready_pattern_e;

  localparam int CLK_PERIOD     = 4;
  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int END_SLACK      = 300;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 200;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_TOP = CFG_IDX_W'(255);

  localparam logic signed [SAMPLE_W-1:0] S_MAX  = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN  = 24'sh800000;
  localparam logic signed [SAMPLE_W-1:0] BIAS_Z = 24'sd3000000;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic [DATA_W-1:0]     s_tdata   = '0;
  logic                  m_tready  = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [DATA_W-1:0]     m_tdata;
  logic [USER_W-1:0]     m_tuser;
  logic                  cfg_ready;
  int                    mismatches;
  int                    pending;

  int                    burst_left = 0;
  logic [THR_W-1:0]      cur_thr    = THRESHOLD_RESET;
  ready_pattern_e        ready_mode = RDY_OPEN;
  int                    mode_left  = 0;

  wrench_bias_calibrate_contact_detect uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  wrench_result_checker result_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("[wrench_bias_calibrate_contact_detect] ERROR");
    $finish;
  end

  // receiver stall pattern, re-picked at random from four patterns
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= ready_pattern_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(20, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      RDY_OPEN:   m_tready <= 1'b1;
      RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
      RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:    m_tready <= ((mode_left % 16) < 3);
    endcase
  end

  function automatic logic [SAMPLE_W-1:0] any_value();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return S_MAX;
    else if (pick == 1) return S_MIN;
    else return SAMPLE_W'($urandom());
  endfunction

  function automatic logic [SAMPLE_W-1:0] z_offset(input int d);
    return SAMPLE_W'(int'(BIAS_Z) + d);
  endfunction

  function automatic wrench_vec_t with_z(input logic [SAMPLE_W-1:0] z);
    wrench_vec_t v;
    for (int i = 0; i < NUM_CH; i++) v[i] = any_value();
    v[2] = z;
    return v;
  endfunction

  // X force biased high, X torque biased low, Z fixed
  function automatic wrench_vec_t cal_sample();
    wrench_vec_t v;
    v    = with_z(BIAS_Z);
    v[0] = SAMPLE_W'(32'd4194304 + $urandom_range(0, 4194303));
    v[3] = SAMPLE_W'(-8388608 + int'($urandom_range(0, 4194304)));
    return v;
  endfunction

  // Z lands on either side of the contact edge about half the time
  function automatic wrench_vec_t corr_sample(input logic [THR_W-1:0] thr);
    longint z;
    z = longint'(BIAS_Z) + longint'($urandom_range(0, 4)) - 2;
    if ($urandom_range(0, 1) == 1) z = z + longint'(thr);
    else z = z - longint'(thr);
    if ($urandom_range(0, 1) == 0 || z > longint'(S_MAX) || z < longint'(S_MIN)) begin
      return with_z(any_value());
    end
    return with_z(z[SAMPLE_W-1:0]);
  endfunction

  task automatic send_sample(input wrench_vec_t v);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(10, 60)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 20);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] thr);
    write_reg(REG_CONTACT_THR, ($urandom() & ~CFG_DATA_W'(32'h7FFFFF)) | CFG_DATA_W'(thr));
    cur_thr = thr;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // calibration, default target of 100 not yet reached
    repeat (99) send_sample(cal_sample());
    wait_results();
    write_reg(REG_BIAS_SAMPLES, 32'hFFFF_FFFF);
    write_reg(REG_UNMAPPED, 32'h0000_0001);
    repeat (5) send_sample(cal_sample());
    wait_results();
    write_reg(REG_BIAS_SAMPLES, 32'd4097);
    repeat (5) send_sample(cal_sample());
    wait_results();
    // zero target below the count: the next sample closes calibration
    write_reg(REG_BIAS_SAMPLES, 32'd0);
    send_sample(cal_sample());
    wait_results();

    // corrected samples, reset threshold
    send_sample({NUM_CH{S_MAX}});
    send_sample({NUM_CH{S_MIN}});
    send_sample('0);
    send_sample(with_z(z_offset(int'(THRESHOLD_RESET))));
    send_sample(with_z(z_offset(int'(THRESHOLD_RESET) + 1)));
    send_sample(with_z(z_offset(-int'(THRESHOLD_RESET))));
    send_sample(with_z(z_offset(-int'(THRESHOLD_RESET) - 1)));
    wait_results();

    set_threshold('0);
    write_reg(REG_BIAS_SAMPLES, 32'd1);
    send_sample(with_z(BIAS_Z));
    send_sample(with_z(z_offset(1)));
    send_sample(with_z(z_offset(-1)));
    wait_results();

    write_reg(REG_CONTACT_THR, 32'hFFFF_FFFF);
    cur_thr = '1;
    send_sample(with_z(S_MIN));
    send_sample(with_z(S_MAX));
    send_sample(with_z(z_offset(-8388607)));
    send_sample(with_z(z_offset(-8388608)));
    wait_results();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: set_threshold(THR_W'($urandom_range(0, 1000)));
        1: set_threshold(THR_W'($urandom()));
        2: set_threshold(THR_W'($urandom_range(0, 3000000)));
        default: set_threshold(($urandom_range(0, 1) == 1) ? '1 : '0);
      endcase
      write_reg(REG_BIAS_SAMPLES, $urandom());
      if ($urandom_range(0, 1) == 1) write_reg(REG_UNMAPPED_TOP, $urandom());
      repeat (PHASE_ITEMS) send_sample(corr_sample(cur_thr));
      wait_results();
    end

    repeat (END_SLACK) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[wrench_bias_calibrate_contact_detect] OK");
    end else begin
      $display("[wrench_bias_calibrate_contact_detect] ERROR");
    end
    $finish;
  end

endmodule
